### sv/qrs_pkg.sv
// Shared types and constants for the quadratic real-root solver.
// Depends on nothing; the top level and the testbench refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

    // Coefficient width, fixed by the port payload
    localparam int COEF_W = 16;

    // Root count codes as reported on the result beat
    localparam logic [1:0] COUNT_NONE = 2'd0;
    localparam logic [1:0] COUNT_ONE  = 2'd1;
    localparam logic [1:0] COUNT_TWO  = 2'd2;
    localparam logic [1:0] COUNT_INF  = 2'd3;

    // Limits of the signed 32-bit root
    localparam logic [31:0] ROOT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] ROOT_MIN = 32'h8000_0000;

    // Case of the equation, decided once the discriminant is known
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_INF,
        KIND_LINEAR,
        KIND_SINGLE,
        KIND_TWO
    } kind_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        logic [1:0]         root_count;
        logic signed [31:0] root_first;
        logic signed [31:0] root_second;
        logic               saturated;
    } root_t;

endpackage

`default_nettype wire

### sv/qrs_sqrt_cell.sv
// One cell of the square-root chain: resolves one root bit per cycle while en is high.
// Uses no package items; instantiated in a row by the top level.
`timescale 1ns / 1ps
`default_nettype none

module qrs_sqrt_cell #(
    parameter int SW  = 33,
    parameter int SBW = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_vld,
    input  wire logic [2*SW-1:0] in_rad,
    input  wire logic [SW-1:0]  in_root,
    input  wire logic [SW:0]    in_rem,
    input  wire logic [SBW-1:0] in_sb,
    output logic                out_vld,
    output logic [2*SW-1:0]     out_rad,
    output logic [SW-1:0]       out_root,
    output logic [SW:0]         out_rem,
    output logic [SBW-1:0]      out_sb
);

    logic [SW+2:0] cur;
    logic [SW+2:0] trial;
    logic          ge;
    logic [SW+2:0] diff;

    // Bring down the next two radicand bits and try the next root bit
    always_comb
    begin
        cur   = {in_rem, in_rad[2*SW-1:2*SW-2]};
        trial = {1'b0, in_root, 2'b01};
        ge    = (cur >= trial);
        diff  = cur - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld <= 1'b0;
        end
        else if (en)
        begin
            out_vld <= in_vld;
        end
    end

    // Advance the partial root, remainder and the rest of the radicand
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rad  <= {in_rad[2*SW-3:0], 2'b00};
            out_root <= {in_root[SW-2:0], ge};
            out_rem  <= ge ? diff[SW:0] : cur[SW:0];
            out_sb   <= in_sb;
        end
    end

endmodule

`default_nettype wire

### sv/qrs_div_cell.sv
// One cell of the divider chain: one quotient bit per cycle, while en is high, for two
// numerators that share a divisor. No package items used.
`timescale 1ns / 1ps
`default_nettype none

module qrs_div_cell #(
    parameter int NMW = 33,
    parameter int DMW = 17,
    parameter int SBW = 5
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_vld,
    input  wire logic [NMW-1:0] in_num1,
    input  wire logic [NMW-1:0] in_num2,
    input  wire logic [DMW-1:0] in_rem1,
    input  wire logic [DMW-1:0] in_rem2,
    input  wire logic [DMW-1:0] in_den,
    input  wire logic [SBW-1:0] in_sb,
    output logic                out_vld,
    output logic [NMW-1:0]      out_num1,
    output logic [NMW-1:0]      out_num2,
    output logic [DMW-1:0]      out_rem1,
    output logic [DMW-1:0]      out_rem2,
    output logic [DMW-1:0]      out_den,
    output logic [SBW-1:0]      out_sb
);

    logic [DMW:0] cur1;
    logic [DMW:0] cur2;
    logic         ge1;
    logic         ge2;
    logic [DMW:0] diff1;
    logic [DMW:0] diff2;

    // Shift in the next numerator bit and trial-subtract the divisor
    always_comb
    begin
        cur1  = {in_rem1, in_num1[NMW-1]};
        cur2  = {in_rem2, in_num2[NMW-1]};
        ge1   = (cur1 >= {1'b0, in_den});
        ge2   = (cur2 >= {1'b0, in_den});
        diff1 = cur1 - {1'b0, in_den};
        diff2 = cur2 - {1'b0, in_den};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld <= 1'b0;
        end
        else if (en)
        begin
            out_vld <= in_vld;
        end
    end

    // Quotient bits replace numerator bits as they shift out
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_num1 <= {in_num1[NMW-2:0], ge1};
            out_num2 <= {in_num2[NMW-2:0], ge2};
            out_rem1 <= ge1 ? diff1[DMW-1:0] : cur1[DMW-1:0];
            out_rem2 <= ge2 ? diff2[DMW-1:0] : cur2[DMW-1:0];
            out_den  <= in_den;
            out_sb   <= in_sb;
        end
    end

endmodule

`default_nettype wire

### sv/quadratic_real_root_solver.sv
// Top level of the quadratic real-root solver: front stages, square-root
// and divider cell chains, clamp and a two-beat output queue. Uses qrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes signed Q8.8 coefficients a, b, c and returns the real roots of
// ax^2+bx+c=0 in signed fixed point with ROOT_FRAC_BITS fraction bits, one
// result beat per coefficient beat, in order. A new beat is taken every
// cycle unless coef_stall holds the pipe. Each beat passes the three front
// stages, the square-root chain (one root bit per cell) and the divider
// chain (one quotient bit per cell) on its way to the output queue. A
// two-beat queue holds results while root_stall is high; the whole pipe
// holds only when that queue is full and a result is due.
module quadratic_real_root_solver #(
    parameter int ROOT_FRAC_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          coef_valid,
    output logic               coef_stall,
    input  wire qrs_pkg::coef_t coef,
    output logic               root_valid,
    input  wire logic          root_stall,
    output qrs_pkg::root_t     roots
);

    localparam int W    = qrs_pkg::COEF_W;
    localparam int R    = ROOT_FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int DW   = 2 * W + 2;
    localparam int SW   = W + R + 1;
    localparam int VW   = 2 * SW;
    localparam int NBW  = W + R + 1;
    localparam int NSW  = W + R + 2;
    localparam int NMW  = W + R + 1;
    localparam int DMW  = W + 1;
    localparam int MAGW = (NMW > 33) ? NMW : 33;

    typedef struct packed {
        qrs_pkg::kind_t        kind;
        logic signed [NBW-1:0] nbase;
        logic signed [DMW-1:0] den;
    } sq_sb_t;

    typedef struct packed {
        qrs_pkg::kind_t kind;
        logic           neg1;
        logic           neg2;
    } dv_sb_t;

    localparam int SQ_SBW = $bits(sq_sb_t);
    localparam int DV_SBW = $bits(dv_sb_t);

    logic en;
    logic push;
    logic pop;

    // Stage 1: products
    logic                 s1_vld_reg;
    logic signed [PW-1:0] s1_bb_reg;
    logic signed [PW-1:0] s1_ac_reg;
    logic signed [W-1:0]  s1_a_reg;
    logic signed [W-1:0]  s1_b_reg;
    logic signed [W-1:0]  s1_c_reg;

    // Stage 2: discriminant and case
    logic signed [DW-1:0] d_next;
    qrs_pkg::kind_t       kind_next;
    logic                 s2_vld_reg;
    logic [VW-1:0]        s2_rad_reg;
    sq_sb_t               s2_sb_reg;
    sq_sb_t               s2_sb_next;
    logic [VW-1:0]        s2_rad_next;

    // Square-root chain
    logic          sq_vld  [SW+1];
    logic [VW-1:0] sq_rad  [SW+1];
    logic [SW-1:0] sq_root [SW+1];
    logic [SW:0]   sq_rem  [SW+1];
    sq_sb_t        sq_sb   [SW+1];

    // Stage 3: numerators to magnitudes
    logic signed [NSW-1:0] n1;
    logic signed [NSW-1:0] n2;
    logic signed [NSW-1:0] root_ext;
    logic [NSW-1:0]        n1_mag;
    logic [NSW-1:0]        n2_mag;
    logic [DMW-1:0]        den_mag;
    sq_sb_t                sq_last;
    dv_sb_t                s3_sb_next;
    logic                  s3_vld_reg;
    logic [NMW-1:0]        s3_num1_reg;
    logic [NMW-1:0]        s3_num2_reg;
    logic [DMW-1:0]        s3_den_reg;
    dv_sb_t                s3_sb_reg;

    // Divider chain
    logic           dv_vld  [NMW+1];
    logic [NMW-1:0] dv_num1 [NMW+1];
    logic [NMW-1:0] dv_num2 [NMW+1];
    logic [DMW-1:0] dv_rem1 [NMW+1];
    logic [DMW-1:0] dv_rem2 [NMW+1];
    logic [DMW-1:0] dv_den  [NMW+1];
    dv_sb_t         dv_sb   [NMW+1];

    // Result and output queue
    dv_sb_t         dv_last;
    logic [32:0]    cl1;
    logic [32:0]    cl2;
    qrs_pkg::root_t res;
    qrs_pkg::root_t head_reg;
    qrs_pkg::root_t tail_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;

    // Clamp a quotient magnitude with its sign; returns {sat, value}
    function automatic logic [32:0] clamp_q(input logic [NMW-1:0] mag,
                                            input logic neg);
        logic [MAGW-1:0] ext;
        logic [32:0]     r;
        ext = MAGW'(mag);
        if (neg)
        begin
            if (ext > MAGW'(qrs_pkg::ROOT_MIN))
                r = {1'b1, qrs_pkg::ROOT_MIN};
            else
                r = {1'b0, 32'(-ext[31:0])};
        end
        else
        begin
            if (ext > MAGW'(qrs_pkg::ROOT_MAX))
                r = {1'b1, qrs_pkg::ROOT_MAX};
            else
                r = {1'b0, ext[31:0]};
        end
        return r;
    endfunction

    // Hold the whole pipe only when a result is due and the queue is full
    assign en         = !(dv_vld[NMW] && (cnt_reg == 2'd2));
    assign coef_stall = !en;
    assign push       = dv_vld[NMW] && en;
    assign root_valid = (cnt_reg != 2'd0);
    assign pop        = root_valid && !root_stall;
    assign roots      = head_reg;

    // Valid bits of stages 1 to 3, then the stage 1 data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= coef_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= sq_vld[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_bb_reg <= coef.coef_b * coef.coef_b;
            s1_ac_reg <= coef.coef_a * coef.coef_c;
            s1_a_reg  <= coef.coef_a;
            s1_b_reg  <= coef.coef_b;
            s1_c_reg  <= coef.coef_c;
        end
    end

    // Stage 2: discriminant, case decode, radicand, base numerator and divisor
    always_comb
    begin
        d_next = DW'(s1_bb_reg) - (DW'(s1_ac_reg) <<< 2);
        if (s1_a_reg == '0)
        begin
            if (s1_b_reg != '0)
                kind_next = qrs_pkg::KIND_LINEAR;
            else if (s1_c_reg == '0)
                kind_next = qrs_pkg::KIND_INF;
            else
                kind_next = qrs_pkg::KIND_NONE;
        end
        else if (d_next == '0)
        begin
            kind_next = qrs_pkg::KIND_SINGLE;
        end
        else if (!d_next[DW-1])
        begin
            kind_next = qrs_pkg::KIND_TWO;
        end
        else
        begin
            kind_next = qrs_pkg::KIND_NONE;
        end

        s2_sb_next.kind = kind_next;
        if (kind_next == qrs_pkg::KIND_LINEAR)
        begin
            s2_sb_next.nbase = (-NBW'(s1_c_reg)) <<< R;
            s2_sb_next.den   = DMW'(s1_b_reg);
        end
        else
        begin
            s2_sb_next.nbase = (-NBW'(s1_b_reg)) <<< R;
            s2_sb_next.den   = DMW'(s1_a_reg) <<< 1;
        end

        if (kind_next == qrs_pkg::KIND_TWO)
            s2_rad_next = VW'({d_next[DW-2:0], {(2 * R){1'b0}}});
        else
            s2_rad_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_rad_reg <= s2_rad_next;
            s2_sb_reg  <= s2_sb_next;
        end
    end

    // Square-root chain, one root bit per cell
    assign sq_vld[0]  = s2_vld_reg;
    assign sq_rad[0]  = s2_rad_reg;
    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;
    assign sq_sb[0]   = s2_sb_reg;

    for (genvar i = 0; i < SW; i++)
    begin : g_sqrt
        qrs_sqrt_cell #(
            .SW  (SW),
            .SBW (SQ_SBW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (sq_vld[i]),
            .in_rad   (sq_rad[i]),
            .in_root  (sq_root[i]),
            .in_rem   (sq_rem[i]),
            .in_sb    (sq_sb[i]),
            .out_vld  (sq_vld[i+1]),
            .out_rad  (sq_rad[i+1]),
            .out_root (sq_root[i+1]),
            .out_rem  (sq_rem[i+1]),
            .out_sb   (sq_sb[i+1])
        );
    end

    // Stage 3: form both numerators, split into sign and magnitude
    always_comb
    begin
        sq_last  = sq_sb[SW];
        root_ext = NSW'({1'b0, sq_root[SW]});
        if (sq_last.kind == qrs_pkg::KIND_TWO)
            n1 = NSW'(sq_last.nbase) + root_ext;
        else
            n1 = NSW'(sq_last.nbase);
        n2      = NSW'(sq_last.nbase) - root_ext;
        n1_mag  = n1[NSW-1] ? NSW'(-n1) : n1;
        n2_mag  = n2[NSW-1] ? NSW'(-n2) : n2;
        den_mag = sq_last.den[DMW-1] ? DMW'(-sq_last.den) : sq_last.den;
        s3_sb_next.kind = sq_last.kind;
        s3_sb_next.neg1 = n1[NSW-1] ^ sq_last.den[DMW-1];
        s3_sb_next.neg2 = n2[NSW-1] ^ sq_last.den[DMW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_num1_reg <= n1_mag[NMW-1:0];
            s3_num2_reg <= n2_mag[NMW-1:0];
            s3_den_reg  <= den_mag;
            s3_sb_reg   <= s3_sb_next;
        end
    end

    // Divider chain, one quotient bit per cell
    assign dv_vld[0]  = s3_vld_reg;
    assign dv_num1[0] = s3_num1_reg;
    assign dv_num2[0] = s3_num2_reg;
    assign dv_rem1[0] = '0;
    assign dv_rem2[0] = '0;
    assign dv_den[0]  = s3_den_reg;
    assign dv_sb[0]   = s3_sb_reg;

    for (genvar j = 0; j < NMW; j++)
    begin : g_div
        qrs_div_cell #(
            .NMW (NMW),
            .DMW (DMW),
            .SBW (DV_SBW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (dv_vld[j]),
            .in_num1  (dv_num1[j]),
            .in_num2  (dv_num2[j]),
            .in_rem1  (dv_rem1[j]),
            .in_rem2  (dv_rem2[j]),
            .in_den   (dv_den[j]),
            .in_sb    (dv_sb[j]),
            .out_vld  (dv_vld[j+1]),
            .out_num1 (dv_num1[j+1]),
            .out_num2 (dv_num2[j+1]),
            .out_rem1 (dv_rem1[j+1]),
            .out_rem2 (dv_rem2[j+1]),
            .out_den  (dv_den[j+1]),
            .out_sb   (dv_sb[j+1])
        );
    end

    // Clamp and assemble the result beat
    always_comb
    begin
        dv_last = dv_sb[NMW];
        cl1     = clamp_q(dv_num1[NMW], dv_last.neg1);
        cl2     = clamp_q(dv_num2[NMW], dv_last.neg2);
        res     = '0;
        case (dv_last.kind)
            qrs_pkg::KIND_INF:
            begin
                res.root_count = qrs_pkg::COUNT_INF;
            end
            qrs_pkg::KIND_LINEAR, qrs_pkg::KIND_SINGLE:
            begin
                res.root_count = qrs_pkg::COUNT_ONE;
                res.root_first = cl1[31:0];
                res.saturated  = cl1[32];
            end
            qrs_pkg::KIND_TWO:
            begin
                res.root_count  = qrs_pkg::COUNT_TWO;
                res.root_first  = cl1[31:0];
                res.root_second = cl2[31:0];
                res.saturated   = cl1[32] | cl2[32];
            end
            default:
            begin
                res.root_count = qrs_pkg::COUNT_NONE;
            end
        endcase
    end

    // Output queue: two beats, head drives the port
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cnt_reg == 2'd2)
                head_reg <= tail_reg;
            else if (push)
                head_reg <= res;
            if (push && (cnt_reg == 2'd2))
                tail_reg <= res;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
                head_reg <= res;
            else
                tail_reg <= res;
        end
    end

    // Queue never holds more than two beats
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

    // A held pipe keeps its last stage
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv_vld[NMW]))
        else $error("pipe moved while held");

    // Unused roots read zero and no clamp is flagged without a root
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && (roots.root_count == qrs_pkg::COUNT_NONE ||
                       roots.root_count == qrs_pkg::COUNT_INF)
        |-> (roots.root_first == '0) && (roots.root_second == '0)
            && !roots.saturated)
        else $error("root reported with no real root");

    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && (roots.root_count != qrs_pkg::COUNT_TWO)
        |-> (roots.root_second == '0))
        else $error("second root set without two roots");

endmodule

`default_nettype wire

### tb/sv/qrs_checker.sv
// Checker for the quadratic real-root solver: watches both channels,
// predicts each result beat from the coefficients and compares. Uses qrs_pkg.
`timescale 1ns / 1ps

module qrs_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           coef_valid,
    input  wire logic           coef_stall,
    input  wire qrs_pkg::coef_t coef,
    input  wire logic           root_valid,
    input  wire logic           root_stall,
    input  wire qrs_pkg::root_t roots,
    output int                  fail_count,
    output int                  pending,
    output int                  seen
);

    qrs_pkg::root_t expected_roots[$];

    // Floor square root of a 128-bit value, one bit at a time
    function automatic logic [63:0] isqrt(logic [127:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= v)
                r = t;
        end
        return r;
    endfunction

    // Clamp to the signed 32-bit range, flagging saturation
    function automatic logic [31:0] clamp_root(logic signed [127:0] x, inout logic sat);
        if (x > 128'sh7fff_ffff)
        begin
            sat = 1'b1;
            return qrs_pkg::ROOT_MAX;
        end
        if (x < -128'sh8000_0000)
        begin
            sat = 1'b1;
            return qrs_pkg::ROOT_MIN;
        end
        return x[31:0];
    endfunction

    // Work out the root beat for one coefficient beat
    function automatic qrs_pkg::root_t solve_roots(qrs_pkg::coef_t in);
        logic signed [127:0] a, b, c, d, s, nb, den;
        qrs_pkg::root_t r;
        logic sat;
        a = in.coef_a;
        b = in.coef_b;
        c = in.coef_c;
        r = '0;
        sat = 1'b0;
        if (a == 0)
        begin
            if (b == 0)
                r.root_count = (c == 0) ? qrs_pkg::COUNT_INF : qrs_pkg::COUNT_NONE;
            else
            begin
                r.root_count = qrs_pkg::COUNT_ONE;
                r.root_first = clamp_root(((-c) <<< 16) / b, sat);
            end
        end
        else
        begin
            d = b * b - 4 * a * c;
            den = 2 * a;
            nb = (-b) <<< 16;
            if (d == 0)
            begin
                r.root_count = qrs_pkg::COUNT_ONE;
                r.root_first = clamp_root(nb / den, sat);
            end
            else if (d > 0)
            begin
                s = $signed({64'd0, isqrt(d << 32)});
                r.root_count = qrs_pkg::COUNT_TWO;
                r.root_first = clamp_root((nb + s) / den, sat);
                r.root_second = clamp_root((nb - s) / den, sat);
            end
        end
        r.saturated = sat;
        return r;
    endfunction

    // Record accepted coefficient beats, compare accepted root beats
    always @(posedge clk)
    begin
        qrs_pkg::root_t want;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            expected_roots.delete();
            fail_count <= 0;
            seen <= 0;
            pending <= 0;
        end
        else
        begin
            if (coef_valid && !coef_stall)
                expected_roots.push_back(solve_roots(coef));
            if (root_valid && !root_stall)
            begin
                seen <= seen + 1;
                if (expected_roots.size() == 0)
                begin
                    $error("unexpected root beat %p", roots);
                    errs++;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (want.root_count !== roots.root_count)
                    begin
                        $error("root_count expected %0d got %0d", want.root_count,
                               roots.root_count);
                        errs++;
                    end
                    if (want.root_first !== roots.root_first)
                    begin
                        $error("root_first expected %0d got %0d", want.root_first,
                               roots.root_first);
                        errs++;
                    end
                    if (want.root_second !== roots.root_second)
                    begin
                        $error("root_second expected %0d got %0d", want.root_second,
                               roots.root_second);
                        errs++;
                    end
                    if (want.saturated !== roots.saturated)
                    begin
                        $error("saturated expected %0d got %0d", want.saturated,
                               roots.saturated);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            pending <= expected_roots.size();
        end
    end
endmodule

### tb/sv/tb.sv
// Testbench top for the quadratic real-root solver: clock, reset, stimulus
// and verdict. Depends on qrs_pkg, quadratic_real_root_solver and qrs_checker.
`timescale 1ns / 1ps

module tb;

    logic           clk;
    logic           rst_n;
    logic           coef_valid;
    logic           coef_stall;
    qrs_pkg::coef_t coef;
    logic           root_valid;
    logic           root_stall = 1'b0;
    qrs_pkg::root_t roots;
    int             fail_count;
    int             pending;
    int             seen;
    int             cycle_count = 0;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_off = 0;
    logic           hold_req;
    logic           hold_done = 1'b0;

    quadratic_real_root_solver dut (
        .clk(clk), .rst_n(rst_n), .coef_valid(coef_valid), .coef_stall(coef_stall),
        .coef(coef), .root_valid(root_valid), .root_stall(root_stall), .roots(roots)
    );

    qrs_checker checker_i (
        .clk(clk), .rst_n(rst_n), .coef_valid(coef_valid), .coef_stall(coef_stall),
        .coef(coef), .root_valid(root_valid), .root_stall(root_stall), .roots(roots),
        .fail_count(fail_count), .pending(pending), .seen(seen)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Abort on a runaway run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Drive the receiver stall, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            root_stall <= 1'b1;
            hold_off <= 200;
            hold_done <= 1'b1;
        end
        else if (hold_off > 0)
        begin
            root_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
            root_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Pick a coefficient biased towards interesting values
    function automatic logic [15:0] pick_coef();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'h7fff;
            2: return 16'h8000;
            3: return 16'($signed($urandom_range(16)) - 8);
            4: return 16'($signed($urandom_range(1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one beat and hold it until taken, idling first at random
    task automatic send_beat(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            coef_valid <= 1'b0;
            @(negedge clk);
        end
        coef_valid <= 1'b1;
        coef <= '{a, b, c};
        @(posedge clk);
        while (coef_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Offer random beats; a share form perfect squares and real-root cases
    task automatic send_random(int n);
        logic [15:0] a, b, c;
        int r1, r2;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                // (x - r1)(x - r2) scaled by a small leading term
                r1 = $signed($urandom_range(40)) - 20;
                r2 = ($urandom_range(1)) ? r1 : $signed($urandom_range(40)) - 20;
                a = 16'($signed($urandom_range(6)) - 3);
                if (a == 0)
                    a = 1;
                b = 16'(-$signed(a) * (r1 + r2));
                c = 16'($signed(a) * r1 * r2);
            end
            else
            begin
                a = pick_coef();
                b = pick_coef();
                c = pick_coef();
            end
            send_beat(a, b, c);
        end
    endtask

    task automatic drain();
        coef_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        coef_valid = 1'b0;
        coef = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: degenerate cases, extremes, single and double roots
        send_beat(16'h0000, 16'h0000, 16'h0000);
        send_beat(16'h0000, 16'h0000, 16'h0100);
        send_beat(16'h0000, 16'h0100, 16'hfe00);
        send_beat(16'h0000, 16'h0001, 16'h7fff);
        send_beat(16'h0000, 16'hffff, 16'h8000);
        send_beat(16'h0100, 16'hfe00, 16'h0100);
        send_beat(16'h0100, 16'h0000, 16'h0100);
        send_beat(16'h0100, 16'h0000, 16'hff00);
        send_beat(16'h0001, 16'h7fff, 16'h8000);
        send_beat(16'h0001, 16'h8000, 16'h0000);
        send_beat(16'h8000, 16'h8000, 16'h8000);
        send_beat(16'h7fff, 16'h7fff, 16'h7fff);
        send_beat(16'h7fff, 16'h0000, 16'h8000);
        send_beat(16'h8000, 16'h7fff, 16'h7fff);
        send_beat(16'hffff, 16'h0002, 16'hffff);
        send_beat(16'h0001, 16'h0000, 16'h0000);
        send_beat(16'hffff, 16'hffff, 16'hffff);
        send_beat(16'h5555, 16'haaaa, 16'h5555);
        send_beat(16'haaaa, 16'h5555, 16'haaaa);
        drain();

        // Random phases with varied idling
        send_random(400);
        send_idle_pct = 71;
        send_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 71;
        send_random(300);
        send_idle_pct = 33;
        recv_stall_pct = 33;
        send_random(300);

        // Long receiver hold-off so the pipe fills and back-pressures
        send_idle_pct = 0;
        recv_stall_pct = 10;
        hold_req = 1'b1;
        send_random(150);
        drain();

        // A final burst, then a sender pause until every result is in
        send_random(200);
        drain();

        $display("Covered degenerate, linear, single, double and complex cases");
        $display("over %0d result beats under several idle and stall mixes", seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
